>>> rtl/core/hufw_pkg.sv
// Shared types and constants of the Huffman tree-walk decoder.
package hufw_pkg;

	localparam int NODE_COUNT   = 512;
	localparam int NODE_IDX_W   = $clog2(NODE_COUNT);
	localparam int SYM_W        = 16;
	localparam int WORD_BITS    = 32;
	localparam int BIT_CNT_W    = $clog2(WORD_BITS + 1);
	localparam int QUEUE_DEPTH  = 2;
	localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 16;

	localparam logic [NODE_IDX_W-1:0] ROOT_INDEX_RESET   = '0;
	localparam logic [SYM_W-1:0]      EMPTY_SYMBOL_RESET = '1;

	typedef enum logic {
		OP_LOAD   = 1'b0,
		OP_STREAM = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROOT_INDEX   = 1'b0,
		REG_EMPTY_SYMBOL = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_ROOT,
		ST_RD_CUR,
		ST_FIRST,
		ST_WALK,
		ST_FLUSH
	} back_state_t;

	typedef struct packed {
		logic [NODE_IDX_W-1:0] left;
		logic [NODE_IDX_W-1:0] right;
		logic [SYM_W-1:0]      sym;
	} node_t;

	typedef struct packed {
		op_t                   op;
		logic [NODE_IDX_W-1:0] node_index;
		logic [NODE_IDX_W-1:0] left;
		logic [NODE_IDX_W-1:0] right;
		logic [SYM_W-1:0]      sym;
		logic [WORD_BITS-1:0]  word;
		logic                  eos;
	} cmd_t;

	typedef struct packed {
		logic [NODE_IDX_W-1:0] root_index;
		logic [SYM_W-1:0]      empty_symbol;
	} cfg_t;

endpackage

>>> rtl/core/hufw_front.sv
// Front end: accepts input transactions, classifies them and queues them for the walk engine.
module hufw_front import hufw_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  operation,
	input  logic [NODE_IDX_W-1:0] node_index,
	input  logic [NODE_IDX_W-1:0] left_child,
	input  logic [NODE_IDX_W-1:0] right_child,
	input  logic [SYM_W-1:0]      node_symbol,
	input  logic [WORD_BITS-1:0]  stream_word,
	input  logic                  end_of_stream,
	output logic                  cmd_valid,
	output cmd_t                  cmd,
	input  logic                  cmd_pop
);

	cmd_t                   queue_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] cnt_q;
	logic                   push;
	cmd_t                   new_cmd;

	assign in_stall  = (cnt_q == QUEUE_CNT_W'(QUEUE_DEPTH));
	assign push      = in_valid && !in_stall;
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = queue_q[rd_ptr_q];

	always_comb begin
		new_cmd            = '0;
		new_cmd.op         = op_t'(operation);
		unique case (op_t'(operation))
			OP_LOAD: begin
				new_cmd.node_index = node_index;
				new_cmd.left       = left_child;
				new_cmd.right      = right_child;
				new_cmd.sym        = node_symbol;
			end
			OP_STREAM: begin
				new_cmd.word = stream_word;
				new_cmd.eos  = end_of_stream;
			end
			default: new_cmd = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (cmd_pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !cmd_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && cmd_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QUEUE_CNT_W'(QUEUE_DEPTH))
		else $error("Command queue count exceeds its depth.");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cnt_q != '0)
		else $error("Command queue popped while empty.");

endmodule

>>> rtl/core/hufw_back.sv
// Back end: node memory and the bit-by-bit tree walk with the result register.
module hufw_back import hufw_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             cmd_valid,
	input  cmd_t             cmd,
	output logic             cmd_pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [SYM_W-1:0] symbol,
	output logic             last_of_word
);

	node_t                 mem [NODE_COUNT];
	node_t                 rdata_q;
	node_t                 root_rec_q;
	back_state_t           state_q;
	back_state_t           state_d;
	logic [NODE_IDX_W-1:0] current_q;
	logic                  at_root_q;
	logic [WORD_BITS-1:0]  shift_q;
	logic [BIT_CNT_W-1:0]  bits_q;
	logic [NODE_IDX_W-1:0] pend_q;
	logic                  eos_q;
	logic                  hold_valid_q;
	logic [SYM_W-1:0]      hold_sym_q;
	logic                  out_valid_q;
	logic [SYM_W-1:0]      out_sym_q;
	logic                  out_last_q;

	logic                  out_free;
	logic                  leaf;
	logic                  blocked;
	logic                  use_root;
	node_t                 from_rec;
	logic [NODE_IDX_W-1:0] child;
	logic                  mem_we;
	logic                  rd_en;
	logic [NODE_IDX_W-1:0] raddr;
	logic                  grab_root;
	logic                  step;
	logic                  land;
	logic                  finish;
	logic                  start;
	logic                  push;
	logic [SYM_W-1:0]      push_sym;
	logic                  push_last;

	assign out_free     = !out_valid_q || !out_stall;
	assign leaf         = (rdata_q.sym != cfg.empty_symbol);
	assign blocked      = (state_q == ST_WALK) && leaf && hold_valid_q && !out_free;
	assign use_root     = (state_q == ST_FIRST) ? at_root_q : leaf;
	assign from_rec     = use_root ? root_rec_q : rdata_q;
	assign child        = shift_q[0] ? from_rec.right : from_rec.left;
	assign out_valid    = out_valid_q;
	assign symbol       = out_sym_q;
	assign last_of_word = out_last_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid && cmd.op == OP_STREAM) begin
					state_d = ST_RD_ROOT;
				end
			end
			ST_RD_ROOT: state_d = ST_RD_CUR;
			ST_RD_CUR:  state_d = ST_FIRST;
			ST_FIRST:   state_d = ST_WALK;
			ST_WALK: begin
				if (!blocked && bits_q == '0) begin
					state_d = (hold_valid_q || leaf) ? ST_FLUSH : ST_IDLE;
				end
			end
			ST_FLUSH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop   = 1'b0;
		mem_we    = 1'b0;
		start     = 1'b0;
		rd_en     = 1'b0;
		raddr     = child;
		grab_root = 1'b0;
		step      = 1'b0;
		land      = 1'b0;
		finish    = 1'b0;
		push      = 1'b0;
		push_sym  = hold_sym_q;
		push_last = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd_pop = cmd_valid;
				mem_we  = cmd_valid && cmd.op == OP_LOAD;
				start   = cmd_valid && cmd.op == OP_STREAM;
			end
			ST_RD_ROOT: begin
				rd_en = 1'b1;
				raddr = cfg.root_index;
			end
			ST_RD_CUR: begin
				rd_en     = 1'b1;
				raddr     = current_q;
				grab_root = 1'b1;
			end
			ST_FIRST: begin
				rd_en = 1'b1;
				step  = 1'b1;
			end
			ST_WALK: begin
				if (!blocked) begin
					land = 1'b1;
					push = leaf && hold_valid_q;
					if (bits_q != '0) begin
						rd_en = 1'b1;
						step  = 1'b1;
					end else begin
						finish = 1'b1;
					end
				end
			end
			ST_FLUSH: begin
				push      = out_free;
				push_last = 1'b1;
			end
			default: cmd_pop = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[cmd.node_index] <= '{left: cmd.left, right: cmd.right, sym: cmd.sym};
		end
		if (rd_en) begin
			rdata_q <= mem[raddr];
		end
		if (grab_root) begin
			root_rec_q <= rdata_q;
		end
		if (step) begin
			pend_q <= child;
		end
		if (land && leaf) begin
			hold_sym_q <= rdata_q.sym;
		end
		if (push) begin
			out_sym_q  <= push_sym;
			out_last_q <= push_last;
		end
		if (start) begin
			eos_q <= cmd.eos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			current_q    <= '0;
			at_root_q    <= 1'b1;
			shift_q      <= '0;
			bits_q       <= '0;
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start) begin
				shift_q <= cmd.word;
				bits_q  <= BIT_CNT_W'(WORD_BITS);
			end else if (step) begin
				shift_q <= shift_q >> 1;
				bits_q  <= bits_q - 1'b1;
			end
			if (finish && eos_q) begin
				at_root_q <= 1'b1;
				current_q <= '0;
			end else if (land) begin
				at_root_q <= leaf;
				current_q <= leaf ? '0 : pend_q;
			end
			if (land && leaf) begin
				hold_valid_q <= 1'b1;
			end else if (state_q == ST_FLUSH && out_free) begin
				hold_valid_q <= 1'b0;
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> out_free)
		else $error("Result register overwritten before its transaction completed.");

	a_root_node_zero: assert property (@(posedge clk) disable iff (!arst_n)
		at_root_q |-> current_q == '0)
		else $error("Walk at the root with a nonzero current node.");

	a_flush_has_symbol: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FLUSH |-> hold_valid_q)
		else $error("Flush state entered without a held symbol.");

	a_walk_bits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK |-> bits_q < BIT_CNT_W'(WORD_BITS))
		else $error("Bit count out of range during the walk.");

endmodule

>>> rtl/core/huffman_tree_walk_decoder_core.sv
// Top level of the Huffman tree-walk decoder: configuration registers and the two halves.
// A load transaction writes one tree node while the walk engine is idle. A stream transaction
// is taken by the walk engine, which fetches the root and current node records and then
// walks the word one bit at a time, because every step depends on the registered read of
// the node memory it just addressed; a last check of the node reached by the final bit
// follows, then a flush of the held symbol when the word completes any symbol.
// A two-entry command queue lets new transactions be taken while a word is being walked, and
// a stalled result holds the walk only when a second symbol is ready. The configuration port is
// always ready; the user must write it only while no transaction is in flight (not enforced).
module huffman_tree_walk_decoder_core import hufw_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  operation,
	input  logic [NODE_IDX_W-1:0] node_index,
	input  logic [NODE_IDX_W-1:0] left_child,
	input  logic [NODE_IDX_W-1:0] right_child,
	input  logic [SYM_W-1:0]      node_symbol,
	input  logic [WORD_BITS-1:0]  stream_word,
	input  logic                  end_of_stream,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [SYM_W-1:0]      symbol,
	output logic                  last_of_word
);

	cfg_t cfg_q;
	logic cmd_valid;
	cmd_t cmd;
	logic cmd_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.root_index   <= ROOT_INDEX_RESET;
			cfg_q.empty_symbol <= EMPTY_SYMBOL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_ROOT_INDEX:   cfg_q.root_index   <= cfg_data[NODE_IDX_W-1:0];
				REG_EMPTY_SYMBOL: cfg_q.empty_symbol <= cfg_data[SYM_W-1:0];
				default:          cfg_q <= cfg_q;
			endcase
		end
	end

	hufw_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.operation     (operation),
		.node_index    (node_index),
		.left_child    (left_child),
		.right_child   (right_child),
		.node_symbol   (node_symbol),
		.stream_word   (stream_word),
		.end_of_stream (end_of_stream),
		.cmd_valid     (cmd_valid),
		.cmd           (cmd),
		.cmd_pop       (cmd_pop)
	);

	hufw_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_pop      (cmd_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.symbol       (symbol),
		.last_of_word (last_of_word)
	);

endmodule
